/* hw/rtl/assert_macros.svh */
// Shared concurrent assertion macros, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hbrg_pkg.sv */
package hbrg_pkg;

    localparam logic [31:0] MIX_K1 = 32'h7feb352d;
    localparam logic [31:0] MIX_K2 = 32'h846ca68b;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_NEXT  = 2'd0;
    localparam t_cmd CMD_COORD = 2'd1;
    localparam t_cmd CMD_CUBE  = 2'd2;
    localparam t_cmd CMD_NONE  = 2'd3;

    typedef logic [4:0] t_addr;
    localparam t_addr ADDR_NEXT  = 5'd0;
    localparam t_addr ADDR_COORD = 5'd3;
    localparam t_addr ADDR_CUBE  = 5'd13;
    localparam t_addr ADDR_LAST  = 5'd17;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_A,
        MUL_B
    } t_mul_op;

    typedef enum logic [2:0] {
        SRC_SEQ,
        SRC_Y,
        SRC_XF,
        SRC_Z,
        SRC_SEED,
        SRC_FIN
    } t_src;

    typedef enum logic [1:0] {
        C_NONE,
        C_LOAD,
        C_XOR
    } t_c_op;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_SEQ,
        OUT_KEY,
        OUT_CX,
        OUT_CY,
        OUT_CZ
    } t_out_op;

    typedef struct packed {
        t_mul_op mul;
        t_src    src;
        t_c_op   c_op;
        t_out_op out_op;
        logic    br_cube;
        logic    last;
        t_addr   target;
    } t_uword;

    typedef struct packed {
        logic   go;
        t_uword uw;
    } t_dp_ctrl;

    typedef struct packed {
        logic  busy;
        t_addr pc;
    } t_seq_stat;

    typedef struct packed {
        logic        [31:0] raw;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] fz;
    } t_result;

    function automatic logic signed [23:0] frac_q23(input logic [31:0] v);
        frac_q23 = {~v[22], v[21:0], 1'b0};
    endfunction

endpackage

/* hw/rtl/hbrg_rom.sv */
module hbrg_rom import hbrg_pkg::*; (
    input  t_addr  i_addr,
    output t_uword o_uw
);

    always_comb begin
        unique case (i_addr)
            5'd0:  o_uw = '{MUL_A,    SRC_SEQ,  C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd1:  o_uw = '{MUL_B,    SRC_SEQ,  C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd2:  o_uw = '{MUL_NONE, SRC_SEQ,  C_NONE, OUT_SEQ,  1'b0, 1'b1, ADDR_NEXT};
            5'd3:  o_uw = '{MUL_A,    SRC_Y,    C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd4:  o_uw = '{MUL_B,    SRC_Y,    C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd5:  o_uw = '{MUL_A,    SRC_XF,   C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd6:  o_uw = '{MUL_B,    SRC_XF,   C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd7:  o_uw = '{MUL_A,    SRC_Z,    C_LOAD, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd8:  o_uw = '{MUL_B,    SRC_Z,    C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd9:  o_uw = '{MUL_A,    SRC_SEED, C_XOR,  OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd10: o_uw = '{MUL_B,    SRC_SEED, C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd11: o_uw = '{MUL_NONE, SRC_SEED, C_NONE, OUT_NONE, 1'b1, 1'b0, ADDR_CUBE};
            5'd12: o_uw = '{MUL_NONE, SRC_SEED, C_NONE, OUT_KEY,  1'b0, 1'b1, ADDR_NEXT};
            5'd13: o_uw = '{MUL_A,    SRC_FIN,  C_NONE, OUT_CX,   1'b0, 1'b0, ADDR_NEXT};
            5'd14: o_uw = '{MUL_B,    SRC_FIN,  C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd15: o_uw = '{MUL_A,    SRC_FIN,  C_NONE, OUT_CY,   1'b0, 1'b0, ADDR_NEXT};
            5'd16: o_uw = '{MUL_B,    SRC_FIN,  C_NONE, OUT_NONE, 1'b0, 1'b0, ADDR_NEXT};
            5'd17: o_uw = '{MUL_NONE, SRC_FIN,  C_NONE, OUT_CZ,   1'b0, 1'b1, ADDR_NEXT};
            default: o_uw = '{MUL_NONE, SRC_SEQ, C_NONE, OUT_NONE, 1'b0, 1'b1, ADDR_NEXT};
        endcase
    end

endmodule

/* hw/rtl/hbrg_seq.sv */
module hbrg_seq import hbrg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_dp_ctrl  o_ctrl,
    output t_seq_stat o_stat
);

    logic   r_busy, n_busy;
    t_addr  r_pc, n_pc;
    logic   r_cube, n_cube;
    t_uword uw;
    logic   go;

    hbrg_rom u_rom (
        .i_addr (r_pc),
        .o_uw   (uw)
    );

    assign go = r_busy && !(uw.last && i_out_stall);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_cube = r_cube;
        if (!r_busy) begin
            if (i_start && (i_cmd != CMD_NONE)) begin
                n_busy = 1'b1;
                n_cube = (i_cmd == CMD_CUBE);
                n_pc   = (i_cmd == CMD_NEXT) ? ADDR_NEXT : ADDR_COORD;
            end
        end else if (go) begin
            priority if (uw.last) begin
                n_busy = 1'b0;
            end else if (uw.br_cube && r_cube) begin
                n_pc = uw.target;
            end else begin
                n_pc = r_pc + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ADDR_NEXT;
            r_cube <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_cube <= n_cube;
        end
    end

    assign o_ctrl.go = go;
    assign o_ctrl.uw = uw;
    assign o_stat.busy = r_busy;
    assign o_stat.pc   = r_pc;

endmodule

/* hw/rtl/hbrg_dp.sv */
module hbrg_dp import hbrg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_load,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  t_dp_ctrl    i_ctrl,
    output t_result     o_next_res
);

    logic [31:0] r_seed, r_seq, n_seq;
    logic [31:0] r_x, r_y, r_z;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_c, n_c;
    t_result     r_res, n_res;
    logic [31:0] fin, key, src_val, mul_in, mul_k, mul_out;

    assign fin = r_acc ^ (r_acc >> 16);
    assign key = r_c ^ fin;

    always_comb begin
        unique case (i_ctrl.uw.src)
            SRC_SEQ:  src_val = r_seq;
            SRC_Y:    src_val = r_y;
            SRC_XF:   src_val = r_x ^ fin;
            SRC_Z:    src_val = r_z;
            SRC_SEED: src_val = r_seed;
            SRC_FIN:  src_val = fin;
            default:  src_val = r_seq;
        endcase
    end

    always_comb begin
        if (i_ctrl.uw.mul == MUL_B) begin
            mul_in = r_acc ^ (r_acc >> 15);
            mul_k  = MIX_K2;
        end else begin
            mul_in = src_val ^ (src_val >> 16);
            mul_k  = MIX_K1;
        end
    end

    assign mul_out = mul_in * mul_k;

    always_comb begin
        n_acc = r_acc;
        n_c   = r_c;
        n_seq = r_seq;
        n_res = r_res;
        if (i_ctrl.go) begin
            if (i_ctrl.uw.mul != MUL_NONE) begin
                n_acc = mul_out;
            end
            unique case (i_ctrl.uw.c_op)
                C_LOAD:  n_c = fin;
                C_XOR:   n_c = r_c ^ fin;
                default: n_c = r_c;
            endcase
            unique case (i_ctrl.uw.out_op)
                OUT_SEQ: begin
                    n_seq     = fin;
                    n_res.raw = fin;
                    n_res.fx  = frac_q23(fin);
                    n_res.fy  = '0;
                    n_res.fz  = '0;
                end
                OUT_KEY: begin
                    n_res.raw = key;
                    n_res.fx  = frac_q23(key);
                    n_res.fy  = '0;
                    n_res.fz  = '0;
                end
                OUT_CX: begin
                    n_res.raw = r_c;
                    n_res.fx  = frac_q23(key);
                end
                OUT_CY:  n_res.fy = frac_q23(key);
                OUT_CZ:  n_res.fz = frac_q23(key);
                default: n_res = r_res;
            endcase
        end
        if (i_cfg_we) begin
            n_seq = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_seq  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
            r_z <= i_coord_z;
        end
        r_acc <= n_acc;
        r_c   <= n_c;
        r_res <= n_res;
    end

    assign o_next_res = n_res;

endmodule

/* hw/rtl/hash_based_random_generator_32_top.sv */
// Channel  | Handshake          | Payload
// request  | i_valid / o_ready  | i_command, i_coord_x, i_coord_y, i_coord_z
// result   | o_valid / i_ready  | o_raw_value, o_frac_x, o_frac_y, o_frac_z
// config   | i_cfg_we           | i_cfg_data (seed)
//
// A request is accepted while the block is idle and then runs its microprogram: 3 steps for
// command 0, 10 for command 1 and 14 for command 2, one shared 32-bit multiplier
// doing at most one of the two multiplies of a hash in each step.
// Command 3 is accepted and dropped with no result, and the block stays ready.
// A finished result waits in the output register; the last step stalls only if the
// previous result is still not taken. Reset is synchronous and active low.
`include "assert_macros.svh"

module hash_based_random_generator_32_top import hbrg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_coord_x,
    input  logic [31:0]        i_coord_y,
    input  logic [31:0]        i_coord_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_raw_value,
    output logic signed [23:0] o_frac_x,
    output logic signed [23:0] o_frac_y,
    output logic signed [23:0] o_frac_z
);

    t_dp_ctrl  ctrl;
    t_seq_stat stat;
    t_result   next_res;
    logic      accept, out_stall, out_load;
    logic      r_valid, n_valid;
    t_result   r_out;

    assign o_ready   = !stat.busy;
    assign accept    = i_valid && o_ready;
    assign out_stall = r_valid && !i_ready;
    assign out_load  = ctrl.go && ctrl.uw.last;

    hbrg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_cmd       (i_command),
        .i_out_stall (out_stall),
        .o_ctrl      (ctrl),
        .o_stat      (stat)
    );

    hbrg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_load     (accept),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_coord_z  (i_coord_z),
        .i_ctrl     (ctrl),
        .o_next_res (next_res)
    );

    always_comb begin
        n_valid = r_valid;
        if (out_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= next_res;
        end
    end

    assign o_valid     = r_valid;
    assign o_raw_value = r_out.raw;
    assign o_frac_x    = r_out.fx;
    assign o_frac_y    = r_out.fy;
    assign o_frac_z    = r_out.fz;

    `HBRG_ASSERT_NEXT(a_unused_cmd_idle, accept && (i_command == CMD_NONE), o_ready, "busy")
    `HBRG_ASSERT_SAME(a_pc_in_program, stat.busy, stat.pc <= ADDR_LAST, "step out of range")
    `HBRG_ASSERT_SAME(a_load_not_over, out_load, !out_stall, "result overwritten")
    `HBRG_ASSERT_NEXT(a_load_sets_valid, out_load, o_valid, "result not presented")

endmodule

/* tb/hash_based_random_generator_32_top_tb.sv */
module hash_based_random_generator_32_top_tb;
    import hbrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_ERROR_LINES = 50;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_command;
    logic [31:0]        i_coord_x;
    logic [31:0]        i_coord_y;
    logic [31:0]        i_coord_z;
    logic               o_valid;
    logic               i_ready;
    logic [31:0]        o_raw_value;
    logic signed [23:0] o_frac_x;
    logic signed [23:0] o_frac_y;
    logic signed [23:0] o_frac_z;

    t_req        request_q[$];
    t_result     result_q[$];
    logic [31:0] gen_seed;
    logic [31:0] seq_state;
    int          err_count;
    int          n_issued;
    int          n_accepted;
    bit          req_taken;
    int          burst_left;
    int          gap_left;
    bit          hold_req;
    int          hold_left;
    int          rx_mode;
    int          rx_mode_left;
    bit          rx_ready_next;
    t_req        cur_req;
    t_result     got_result;
    t_result     new_result;
    logic [31:0] seed_list[8];
    int          base_count;

    hash_based_random_generator_32_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_raw_value (o_raw_value),
        .o_frac_x    (o_frac_x),
        .o_frac_y    (o_frac_y),
        .o_frac_z    (o_frac_z)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] lowbias_hash(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v >> 16);
        t = t * MIX_K1;
        t = t ^ (t >> 15);
        t = t * MIX_K2;
        return t ^ (t >> 16);
    endfunction

    function automatic logic signed [23:0] to_q23(input logic [31:0] v);
        logic [23:0] m;
        m = {1'b0, v[22:0]};
        return (m << 1) - 24'h800000;
    endfunction

    // Commands 0 to 2 give one result; the sequence value moves only on command 0.
    function automatic bit predict_result(input t_req r, output t_result res);
        logic [31:0] coord_h;
        logic [31:0] s;
        bit          has_result;
        res = '0;
        has_result = 1'b1;
        coord_h = lowbias_hash(r.x ^ lowbias_hash(r.y)) ^ lowbias_hash(r.z);
        s = lowbias_hash(gen_seed);
        case (r.cmd)
            CMD_NEXT: begin
                seq_state = lowbias_hash(seq_state);
                res.raw = seq_state;
                res.fx = to_q23(seq_state);
            end
            CMD_COORD: begin
                res.raw = coord_h ^ s;
                res.fx = to_q23(coord_h ^ s);
            end
            CMD_CUBE: begin
                res.raw = coord_h;
                res.fx = to_q23(coord_h ^ s);
                s = lowbias_hash(s);
                res.fy = to_q23(coord_h ^ s);
                s = lowbias_hash(s);
                res.fz = to_q23(coord_h ^ s);
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
        return has_result;
    endfunction

    task automatic flag_error(input string msg);
        if (err_count < MAX_ERROR_LINES) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            r.cmd = CMD_NEXT;
        end else if (sel < 7) begin
            r.cmd = CMD_COORD;
        end else if (sel < 9) begin
            r.cmd = CMD_CUBE;
        end else begin
            r.cmd = CMD_NONE;
        end
        r.x = pick_coord();
        r.y = pick_coord();
        r.z = pick_coord();
        return r;
    endfunction

    task automatic add_request(input t_cmd c, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        request_q.push_back('{cmd: c, x: x, y: y, z: z});
    endtask

    task automatic add_random(input int count);
        repeat (count) request_q.push_back(random_request());
    endtask

    // Waits until every queued request has been accepted and answered.
    task automatic wait_idle();
        while (request_q.size() != 0 || n_accepted != n_issued || result_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        gen_seed = v;
        seq_state = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= $urandom;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !req_taken)) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (request_q.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                cur_req = request_q.pop_front();
                n_issued++;
                i_command <= cur_req.cmd;
                i_coord_x <= cur_req.x;
                i_coord_y <= cur_req.y;
                i_coord_z <= cur_req.z;
                i_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rx_ready_next = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
            rx_ready_next = 1'b0;
        end else begin
            if (rx_mode_left <= 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: rx_ready_next = 1'b1;
                1: rx_ready_next = ($urandom_range(0, 1) == 1);
                2: rx_ready_next = ($urandom_range(0, 3) == 0);
                default: rx_ready_next = ($urandom_range(0, 7) != 0);
            endcase
        end
        i_ready <= rx_ready_next;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    flag_error($sformatf("unexpected result raw_value %h", o_raw_value));
                end else begin
                    got_result = result_q.pop_front();
                    if (o_raw_value !== got_result.raw) begin
                        flag_error($sformatf("raw_value got %h want %h",
                                             o_raw_value, got_result.raw));
                    end
                    if (o_frac_x !== got_result.fx) begin
                        flag_error($sformatf("frac_x got %h want %h", o_frac_x, got_result.fx));
                    end
                    if (o_frac_y !== got_result.fy) begin
                        flag_error($sformatf("frac_y got %h want %h", o_frac_y, got_result.fy));
                    end
                    if (o_frac_z !== got_result.fz) begin
                        flag_error($sformatf("frac_z got %h want %h", o_frac_z, got_result.fz));
                    end
                end
            end
            if (i_valid && o_ready) begin
                req_taken = 1'b1;
                n_accepted++;
                if (predict_result('{cmd: i_command, x: i_coord_x, y: i_coord_y,
                                     z: i_coord_z}, new_result)) begin
                    result_q.push_back(new_result);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("hash_based_random_generator_32_top verification failed");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 32'h0;
        i_valid = 1'b0;
        i_command = CMD_NEXT;
        i_coord_x = 32'h0;
        i_coord_y = 32'h0;
        i_coord_z = 32'h0;
        i_ready = 1'b0;
        gen_seed = 32'h0;
        seq_state = 32'h0;
        err_count = 0;
        n_issued = 0;
        n_accepted = 0;
        req_taken = 1'b0;
        burst_left = 1;
        gap_left = 0;
        hold_req = 1'b0;
        hold_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        seed_list[0] = 32'hFFFFFFFF;
        seed_list[1] = 32'h00000000;
        seed_list[2] = 32'h80000000;
        seed_list[3] = 32'h00000001;
        seed_list[4] = $urandom;
        seed_list[5] = $urandom;
        seed_list[6] = 32'h7FFFFFFF;
        seed_list[7] = $urandom;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The seed keeps its reset value for the first requests.
        add_request(CMD_NEXT, 32'h0, 32'h0, 32'h0);
        add_request(CMD_NEXT, 32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF);
        add_request(CMD_COORD, 32'h0, 32'h0, 32'h0);
        add_request(CMD_COORD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(CMD_COORD, 32'hFFFFFFFF, 32'h0, 32'h0);
        add_request(CMD_COORD, 32'h0, 32'hFFFFFFFF, 32'h0);
        add_request(CMD_COORD, 32'h0, 32'h0, 32'hFFFFFFFF);
        add_request(CMD_CUBE, 32'h0, 32'h0, 32'h0);
        add_request(CMD_CUBE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(CMD_CUBE, 32'hAAAAAAAA, 32'h55555555, 32'h80000000);
        add_request(CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(CMD_NONE, 32'h0, 32'h0, 32'h0);
        add_request(CMD_NEXT, 32'h0, 32'h0, 32'h0);
        add_request(CMD_CUBE, 32'h1, 32'h2, 32'h3);
        add_request(CMD_NONE, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'h1);
        add_request(CMD_COORD, 32'h7FFFFFFF, 32'h80000000, 32'h1);
        add_request(CMD_NEXT, 32'h0, 32'h0, 32'h0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_seed(seed_list[p]);
            add_request(CMD_NEXT, 32'h0, 32'h0, 32'h0);
            add_request(CMD_CUBE, 32'h0, 32'h0, 32'h0);
            if (p == 2) begin
                base_count = n_accepted;
                add_random(PHASE_ITEMS);
                while (n_accepted < base_count + 20) @(negedge i_clk);
                @(posedge i_clk);
                hold_req = 1'b1;
            end else if (p == 4) begin
                add_random(PHASE_ITEMS / 2);
                wait_idle();
                add_random(PHASE_ITEMS / 2);
            end else begin
                add_random(PHASE_ITEMS);
            end
            wait_idle();
        end

        if (err_count == 0) begin
            $display("hash_based_random_generator_32_top verification clean");
        end else begin
            $display("hash_based_random_generator_32_top verification failed");
        end
        $finish;
    end

endmodule

/* hash_based_random_generator_32_top.f */
+incdir+hw/rtl
hw/rtl/hbrg_pkg.sv
hw/rtl/hbrg_rom.sv
hw/rtl/hbrg_seq.sv
hw/rtl/hbrg_dp.sv
hw/rtl/hash_based_random_generator_32_top.sv
tb/hash_based_random_generator_32_top_tb.sv
